// File: hw/rtl/astc_pkg.sv
// Shared types, constants and helpers for the ASTC 4x4 block decoder.
package astc_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned NUM_TEXELS  = 16;
	localparam int unsigned NUM_EP      = 8;

	localparam logic [10:0] MODE_ACCEPTED = 11'h042;
	localparam logic [1:0]  PARTS_SINGLE  = 2'd0;
	localparam logic [3:0]  CEM_RGBA_DIR  = 4'd12;

	localparam int unsigned EP_BASE     = 17;
	localparam int unsigned WEIGHT_TOP  = 127;

	// Input transaction: one compressed block
	typedef struct packed {
		logic [63:0] block_low;
		logic [63:0] block_high;
	} blk_in_t;

	// Result transaction: one texel
	typedef struct packed {
		logic [3:0] texel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       supported;
		logic       last;
	} texel_out_t;

	// Classified block handed from front to back
	typedef struct packed {
		logic                          supported;
		logic [NUM_EP-1:0][7:0]        ep;
		logic [NUM_TEXELS-1:0][1:0]    wcode;
	} cls_item_t;

	// Map a 2-bit weight code to its 0..64 weight
	function automatic logic [6:0] weight_of(input logic [1:0] code);
		logic [6:0] w;
		unique case (code)
			2'd0: w = 7'd0;
			2'd1: w = 7'd21;
			2'd2: w = 7'd43;
			2'd3: w = 7'd64;
			default: w = 7'd0;
		endcase
		return w;
	endfunction

	// Interpolate byte-replicated endpoints and keep the top byte
	function automatic logic [7:0] lerp8(input logic [7:0] e0, input logic [7:0] e1,
		input logic [6:0] w);
		logic [15:0] a;
		logic [15:0] b;
		logic [6:0]  wi;
		logic [22:0] acc;
		a   = {e0, e0};
		b   = {e1, e1};
		wi  = 7'd64 - w;
		acc = 23'(a) * 23'(wi) + 23'(b) * 23'(w) + 23'd32;
		return acc[21:14];
	endfunction

endpackage

// File: hw/rtl/astc_front.sv
// Front end: accepts blocks, checks the configuration and unpacks fields.
module astc_front (
	input  logic                 start,
	input  logic                 full,
	input  astc_pkg::blk_in_t    block,
	output logic                 push,
	output astc_pkg::cls_item_t  item
);

	logic [127:0] bits;
	logic         ok;

	assign bits = {block.block_high, block.block_low};
	assign push = start && !full;

	// Classify the block mode, partition count and endpoint mode
	assign ok = (bits[10:0] == astc_pkg::MODE_ACCEPTED)
		&& (bits[12:11] == astc_pkg::PARTS_SINGLE)
		&& (bits[16:13] == astc_pkg::CEM_RGBA_DIR);

	// Unpack endpoints upward and weights downward; zero endpoints give zero texels
	always_comb begin
		item.supported = ok;
		for (int i = 0; i < astc_pkg::NUM_EP; i++) begin
			item.ep[i] = ok ? bits[astc_pkg::EP_BASE + 8 * i +: 8] : 8'd0;
		end
		for (int i = 0; i < astc_pkg::NUM_TEXELS; i++) begin
			item.wcode[i] = {bits[astc_pkg::WEIGHT_TOP - 1 - 2 * i],
				bits[astc_pkg::WEIGHT_TOP - 2 * i]};
		end
	end

endmodule

// File: hw/rtl/astc_queue.sv
// Small queue of classified blocks between front and back.
module astc_queue #(
	parameter int unsigned DEPTH = astc_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  astc_pkg::cls_item_t  wr_item,
	input  logic                 pop,
	output logic                 full,
	output logic                 nonempty,
	output astc_pkg::cls_item_t  rd_item
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	astc_pkg::cls_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/astc_back.sv
// Back end: walks the sixteen texels of a block and interpolates each one.
module astc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 nonempty,
	input  astc_pkg::cls_item_t  head,
	output logic                 pop,
	output logic                 strobe,
	output astc_pkg::texel_out_t texel
);

	astc_pkg::cls_item_t cur_q;
	logic                act_q;
	logic [3:0]          cnt_q;
	logic                strobe_q;
	astc_pkg::texel_out_t texel_q;
	logic                fin;
	logic [6:0]          w;

	assign fin    = act_q && (cnt_q == 4'(astc_pkg::NUM_TEXELS - 1));
	assign pop    = nonempty && (!act_q || fin);
	assign w      = astc_pkg::weight_of(cur_q.wcode[cnt_q]);
	assign strobe = strobe_q;
	assign texel  = texel_q;

	// Load the next block and step the texel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= act_q;
			if (pop) begin
				act_q <= 1'b1;
				cnt_q <= '0;
			end else if (fin) begin
				act_q <= 1'b0;
			end else if (act_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Hold the current block
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	// Register one texel result
	always_ff @(posedge clk) begin
		texel_q.texel_index <= cnt_q;
		texel_q.red         <= astc_pkg::lerp8(cur_q.ep[0], cur_q.ep[1], w);
		texel_q.green       <= astc_pkg::lerp8(cur_q.ep[2], cur_q.ep[3], w);
		texel_q.blue        <= astc_pkg::lerp8(cur_q.ep[4], cur_q.ep[5], w);
		texel_q.alpha       <= astc_pkg::lerp8(cur_q.ep[6], cur_q.ep[7], w);
		texel_q.supported   <= cur_q.supported;
		texel_q.last        <= (cnt_q == 4'(astc_pkg::NUM_TEXELS - 1));
	end

endmodule

// File: hw/rtl/astc_4x4_block_decoder.sv
// Top level of the ASTC 4x4 block decoder: front, queue and texel back end.
// With the back end idle, an accepted block is written to the queue, loaded into the back end's
// current-block register and its first texel registered; the other 15 texels follow on consecutive cycles.
// Throughput: one texel per cycle while a block is in progress; the back end texel counter steps
// through the sixteen texels of a block, and the queue lets a new block be accepted while one is being emitted.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset (arst_n low) empties the queue and stops any block in progress.
module astc_4x4_block_decoder #(
	parameter int unsigned QDEPTH = astc_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  astc_pkg::blk_in_t    block,
	output logic                 strobe,
	output astc_pkg::texel_out_t texel
);

	logic                push;
	logic                pop;
	logic                full;
	logic                nonempty;
	astc_pkg::cls_item_t wr_item;
	astc_pkg::cls_item_t head;

	assign busy = full;

	astc_front u_front (
		.start (start),
		.full  (full),
		.block (block),
		.push  (push),
		.item  (wr_item)
	);

	astc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (wr_item),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.rd_item  (head)
	);

	astc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.strobe   (strobe),
		.texel    (texel)
	);

endmodule

// File: tb/tb_astc_4x4_block_decoder.sv
// Self-checking testbench for the ASTC 4x4 block decoder: directed table, then random blocks.
module tb_astc_4x4_block_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_BLOCKS = 440;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned DRAIN_CYCLES  = 24;

	// Header codes used to build rejected blocks, and the accepted header HDR_OK
	localparam logic [10:0] MODE_NEAR      = astc_pkg::MODE_ACCEPTED ^ 11'h001;
	localparam logic [10:0] MODE_HIGH      = astc_pkg::MODE_ACCEPTED | 11'h400;
	localparam logic [10:0] MODE_NONE      = 11'h000;
	localparam logic [1:0]  PARTS_TWO      = 2'd1;
	localparam logic [1:0]  PARTS_THREE    = 2'd2;
	localparam logic [1:0]  PARTS_FOUR     = 2'd3;
	localparam logic [3:0]  CEM_LUM_DIRECT = 4'd0;
	localparam logic [3:0]  CEM_RGBA_BASE  = 4'd13;
	localparam logic [3:0]  CEM_HDR_RGBA   = 4'd15;
	localparam logic [16:0] HDR_OK         = {astc_pkg::CEM_RGBA_DIR, astc_pkg::PARTS_SINGLE,
		astc_pkg::MODE_ACCEPTED};

	// Weight value for each 2-bit weight code
	localparam int unsigned WEIGHT_LUT [4] = '{0, 21, 43, 64};

	// One row of the directed table; colors are only typed in when every texel is equal
	typedef struct {
		logic [16:0] hdr;
		logic [63:0] ep;
		logic [14:0] mid;
		logic [31:0] wts;
		bit          typed;
		logic [31:0] rgba;
		bit          sup;
	} block_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	astc_pkg::blk_in_t    block;
	logic                 strobe;
	astc_pkg::texel_out_t texel;

	astc_pkg::texel_out_t pending_texels[$];
	block_row_t           directed_rows[$];
	int unsigned          mismatch_count;
	int unsigned          cycle_count;

	astc_4x4_block_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.block  (block),
		.strobe (strobe),
		.texel  (texel)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Assemble a 128-bit block from its fields, header at the bottom, weights at the top
	function automatic astc_pkg::blk_in_t pack_block(input logic [16:0] hdr,
		input logic [63:0] ep, input logic [14:0] mid, input logic [31:0] wts);
		logic [127:0]      bits;
		astc_pkg::blk_in_t blk;
		bits = {wts, mid, ep, hdr};
		blk.block_low  = bits[63:0];
		blk.block_high = bits[127:64];
		return blk;
	endfunction

	// Interpolate one channel between byte-replicated endpoints, keep the top byte
	function automatic logic [7:0] blend_channel(input logic [7:0] e0, input logic [7:0] e1,
		input int unsigned w);
		int unsigned a;
		int unsigned b;
		int unsigned acc;
		a   = 32'({e0, e0});
		b   = 32'({e1, e1});
		acc = (a * (64 - w) + b * w + 32) >> 6;
		return acc[15:8];
	endfunction

	// Decode a block into its sixteen expected texels
	function automatic void push_decoded_texels(input astc_pkg::blk_in_t blk);
		logic [127:0]         bits;
		logic [1:0]           code;
		logic [7:0]           chan [4];
		bit                   ok;
		int unsigned          w;
		astc_pkg::texel_out_t t;
		bits = {blk.block_high, blk.block_low};
		ok = bits[10:0] == astc_pkg::MODE_ACCEPTED && bits[12:11] == astc_pkg::PARTS_SINGLE
			&& bits[16:13] == astc_pkg::CEM_RGBA_DIR;
		for (int i = 0; i < astc_pkg::NUM_TEXELS; i++) begin
			code = {bits[126 - 2 * i], bits[127 - 2 * i]};
			w = WEIGHT_LUT[code];
			for (int c = 0; c < 4; c++) begin
				chan[c] = ok ? blend_channel(bits[astc_pkg::EP_BASE + 16 * c +: 8],
					bits[astc_pkg::EP_BASE + 16 * c + 8 +: 8], w) : 8'h00;
			end
			t.texel_index = 4'(i);
			t.red         = chan[0];
			t.green       = chan[1];
			t.blue        = chan[2];
			t.alpha       = chan[3];
			t.supported   = ok;
			t.last        = (i == astc_pkg::NUM_TEXELS - 1);
			pending_texels.push_back(t);
		end
	endfunction

	// Queue sixteen identical texels whose color is known up front
	function automatic void push_flat_texels(input logic [31:0] rgba, input bit sup);
		astc_pkg::texel_out_t t;
		for (int i = 0; i < astc_pkg::NUM_TEXELS; i++) begin
			t.texel_index = 4'(i);
			{t.red, t.green, t.blue, t.alpha} = rgba;
			t.supported = sup;
			t.last      = (i == astc_pkg::NUM_TEXELS - 1);
			pending_texels.push_back(t);
		end
	endfunction

	function automatic void add_row(input logic [16:0] hdr, input logic [63:0] ep,
		input logic [14:0] mid, input logic [31:0] wts, input bit typed,
		input logic [31:0] rgba, input bit sup);
		block_row_t r;
		r.hdr   = hdr;
		r.ep    = ep;
		r.mid   = mid;
		r.wts   = wts;
		r.typed = typed;
		r.rgba  = rgba;
		r.sup   = sup;
		directed_rows.push_back(r);
	endfunction

	// Random block: mostly well-formed headers, some near misses, some pure noise
	function automatic astc_pkg::blk_in_t random_block();
		logic [127:0] bits;
		int unsigned  kind;
		bits = {$urandom, $urandom, $urandom, $urandom};
		kind = $urandom_range(0, 9);
		if (kind < 9) begin
			bits[16:0] = HDR_OK;
		end
		if (kind == 7 || kind == 8) begin
			bits[$urandom_range(0, 16)] ^= 1'b1;
		end
		// occasionally force equal endpoints on every channel
		if ($urandom_range(0, 7) == 0) begin
			for (int c = 0; c < 4; c++) begin
				bits[astc_pkg::EP_BASE + 16 * c + 8 +: 8] = bits[astc_pkg::EP_BASE + 16 * c +: 8];
			end
		end
		return pack_block(bits[16:0], bits[80:17], bits[95:81], bits[127:96]);
	endfunction

	// Hold start for one transaction until it is accepted, after an optional gap
	task automatic send_block(input astc_pkg::blk_in_t blk, input int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		block <= blk;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain_texels();
		start <= 1'b0;
		while (pending_texels.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare each strobed texel with the oldest expectation
	always @(posedge clk) begin
		astc_pkg::texel_out_t want;
		if (arst_n && strobe) begin
			if (pending_texels.size() == 0) begin
				$error("texel_index: expected none, got %0d", texel.texel_index);
				mismatch_count++;
			end else begin
				want = pending_texels.pop_front();
				check_field("texel_index", want.texel_index, texel.texel_index);
				check_field("red", want.red, texel.red);
				check_field("green", want.green, texel.green);
				check_field("blue", want.blue, texel.blue);
				check_field("alpha", want.alpha, texel.alpha);
				check_field("supported", want.supported, texel.supported);
				check_field("last", want.last, texel.last);
			end
		end
	end

	// End the run if it hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		astc_pkg::blk_in_t blk;
		bit                burst;
		int unsigned       gap;
		mismatch_count = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		block  = '0;

		// extremes, every rejected header field, all weight codes
		add_row(17'h00000, 64'h0, 15'h0000, 32'h0, 1, 32'h0, 0);
		add_row(17'h1FFFF, {8{8'hFF}}, 15'h7FFF, 32'hFFFF_FFFF, 1, 32'h0, 0);
		add_row(HDR_OK, 64'h0, 15'h0000, 32'h0, 1, 32'h0, 1);
		add_row(HDR_OK, {8{8'hFF}}, 15'h7FFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1);
		add_row(HDR_OK, 64'h7878_5656_3434_1212, 15'h0000, 32'hA5C3_0F96, 1, 32'h1234_5678, 1);
		add_row(HDR_OK, 64'h9A9A_0101_FEFE_8080, 15'h7FFF, 32'h1B1B_1B1B, 1, 32'h80FE_019A, 1);
		add_row(HDR_OK, 64'hFF00_FF00_FF00_FF00, 15'h0000, 32'h1B1B_1B1B, 0, 32'h0, 0);
		add_row(HDR_OK, 64'h00FF_00FF_00FF_00FF, 15'h0000, 32'hE4E4_E4E4, 0, 32'h0, 0);
		add_row(HDR_OK, 64'hC033_7F80_01FE_A55A, 15'h2AAA, 32'h5555_5555, 0, 32'h0, 0);
		add_row(HDR_OK, 64'h10EF_2DD2_6699_F00F, 15'h5555, 32'hAAAA_AAAA, 0, 32'h0, 0);
		add_row(HDR_OK, 64'hFF00_00FF_80FF_7F00, 15'h7FFF, 32'h0123_4567, 0, 32'h0, 0);
		add_row({astc_pkg::CEM_RGBA_DIR, astc_pkg::PARTS_SINGLE, MODE_NEAR}, {8{8'hAB}},
			15'h0, 32'hFFFF_FFFF, 1, 32'h0, 0);
		add_row({astc_pkg::CEM_RGBA_DIR, astc_pkg::PARTS_SINGLE, MODE_HIGH}, {8{8'h5C}},
			15'h0, 32'h1B1B_1B1B, 1, 32'h0, 0);
		add_row({astc_pkg::CEM_RGBA_DIR, astc_pkg::PARTS_SINGLE, MODE_NONE}, {8{8'hFF}},
			15'h0, 32'h0, 1, 32'h0, 0);
		add_row({astc_pkg::CEM_RGBA_DIR, PARTS_TWO, astc_pkg::MODE_ACCEPTED}, {8{8'h77}},
			15'h0, 32'h0, 1, 32'h0, 0);
		add_row({astc_pkg::CEM_RGBA_DIR, PARTS_THREE, astc_pkg::MODE_ACCEPTED}, {8{8'h77}},
			15'h0, 32'h0, 1, 32'h0, 0);
		add_row({astc_pkg::CEM_RGBA_DIR, PARTS_FOUR, astc_pkg::MODE_ACCEPTED}, {8{8'h77}},
			15'h0, 32'h0, 1, 32'h0, 0);
		add_row({CEM_LUM_DIRECT, astc_pkg::PARTS_SINGLE, astc_pkg::MODE_ACCEPTED}, {8{8'h3C}},
			15'h0, 32'h0, 1, 32'h0, 0);
		add_row({CEM_RGBA_BASE, astc_pkg::PARTS_SINGLE, astc_pkg::MODE_ACCEPTED}, {8{8'h3C}},
			15'h0, 32'h0, 1, 32'h0, 0);
		add_row({CEM_HDR_RGBA, astc_pkg::PARTS_SINGLE, astc_pkg::MODE_ACCEPTED}, {8{8'h3C}},
			15'h0, 32'h0, 1, 32'h0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (directed_rows[i]) begin
			blk = pack_block(directed_rows[i].hdr, directed_rows[i].ep,
				directed_rows[i].mid, directed_rows[i].wts);
			send_block(blk, $urandom_range(0, 7));
			if (directed_rows[i].typed) begin
				push_flat_texels(directed_rows[i].rgba, directed_rows[i].sup);
			end else begin
				push_decoded_texels(blk);
			end
		end

		// let the decoder go fully idle before the random part
		drain_texels();

		// random blocks, in runs of 40 that are either back-to-back bursts or random gaps
		burst = 1'b0;
		for (int n = 0; n < RANDOM_BLOCKS; n++) begin
			if (n % 40 == 0) begin
				burst = $urandom_range(0, 1);
			end
			if (n == RANDOM_BLOCKS / 2) begin
				drain_texels();
			end
			gap = burst ? 0 : $urandom_range(0, 7);
			blk = random_block();
			send_block(blk, gap);
			push_decoded_texels(blk);
		end

		// wait out the remaining texels, then watch for strays
		drain_texels();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
